// ----- rtl/core/lcwc_pkg.sv -----
// Package for the load cell weight conditioner: register indexes, reset values,
// field widths and the structs passed between the core modules.
// No dependencies.
package lcwc_pkg;

    localparam int RAW_W    = 24;
    localparam int DELTA_W  = 25;
    localparam int GAIN_W   = 32;
    localparam int WEIGHT_W = 32;
    localparam int DBAND_W  = 20;
    localparam int FRAC_W   = 20;
    localparam int PROD_W   = RAW_W + GAIN_W;
    localparam int QUOT_W   = PROD_W + 1 - FRAC_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 96;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q20     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZB_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZB_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZB_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_MG  = 3'd5;

    // reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET     = 32'd582542;
    localparam logic [DBAND_W-1:0] DEADBAND_RESET = 20'd20000;

    typedef struct packed {
        logic signed [RAW_W-1:0] tare_offset;
        logic [GAIN_W-1:0]       gain_q20;
        logic signed [RAW_W-1:0] zb_low;
        logic signed [RAW_W-1:0] zb_high;
        logic                    zb_enable;
        logic [DBAND_W-1:0]      deadband_mg;
    } t_cfg;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic signed [DELTA_W-1:0]  delta;
        logic                       in_band;
    } t_scale_res;

endpackage

// ----- rtl/core/load_cell_weight_conditioner_unit.sv -----
// Top level of the load cell weight conditioner: config registers, input and
// result registers, stream handshake. Depends on lcwc_pkg, lcwc_scale, lcwc_smooth.
//
// Usage:
//  - s_axis: one raw converter sample per word (tdata = raw_sample, 24 bits).
//  - m_axis: one result word per sample; tdata carries display weight,
//    smoothed weight and tare-corrected counts, tuser flags the zero band.
//  - cfg: register writes (index, data); always ready. Write only while idle.
// Data path: a word taken sits in the input register; its result is registered
// in the result register when that stage advances and is presented on m_axis.
// Throughput: one word per cycle unless m_axis_tready stalls the result stage.
// The input register feeds the scale multiply, saturation, EMA update and
// deadband compare combinationally; EMA state and result registers load together.
// Stalls: if m_axis_tready is low the result register holds, the input
// register holds its word, and s_axis_tready drops only once both are full.
// Reset (i_rst_n low, synchronous): both stages empty, EMA state cleared so
// the next sample loads the smoother directly, registers to default values.
module load_cell_weight_conditioner_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [23:0] raw_sample
    input  logic [lcwc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // stream out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] display_weight_mg, [63:32] smoothed_weight_mg,
    // [88:64] delta_counts, [95:89] zero
    output logic [lcwc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] in_zero_band
    output logic                                 m_axis_tuser,
    // config write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lcwc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lcwc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lcwc_pkg::*;

    // config registers
    t_cfg r_cfg;

    // input stage
    logic                    r_in_valid;
    logic signed [RAW_W-1:0] r_raw;

    // result stage
    logic                       r_out_valid;
    logic signed [WEIGHT_W-1:0] r_display;
    logic signed [WEIGHT_W-1:0] r_smoothed;
    logic signed [DELTA_W-1:0]  r_delta;
    logic                       r_in_band;

    logic                       advance;
    logic                       in_take;
    t_scale_res                 scale_res;
    logic signed [WEIGHT_W-1:0] smoothed;
    logic signed [WEIGHT_W-1:0] display;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tare_offset <= '0;
            r_cfg.gain_q20    <= GAIN_RESET;
            r_cfg.zb_low      <= '0;
            r_cfg.zb_high     <= '0;
            r_cfg.zb_enable   <= 1'b0;
            r_cfg.deadband_mg <= DEADBAND_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARE_OFFSET: r_cfg.tare_offset <= $signed(i_cfg_data[RAW_W-1:0]);
                CFG_GAIN_Q20:    r_cfg.gain_q20    <= i_cfg_data[GAIN_W-1:0];
                CFG_ZB_LOW:      r_cfg.zb_low      <= $signed(i_cfg_data[RAW_W-1:0]);
                CFG_ZB_HIGH:     r_cfg.zb_high     <= $signed(i_cfg_data[RAW_W-1:0]);
                CFG_ZB_ENABLE:   r_cfg.zb_enable   <= i_cfg_data[0];
                CFG_DEADBAND_MG: r_cfg.deadband_mg <= i_cfg_data[DBAND_W-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // result stage moves when it is empty or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw <= $signed(s_axis_tdata[RAW_W-1:0]);
        end
    end

    lcwc_scale u_scale (
        .i_raw (r_raw),
        .i_cfg (r_cfg),
        .o_res (scale_res)
    );

    lcwc_smooth u_smooth (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_weight      (scale_res.weight),
        .i_deadband_mg (r_cfg.deadband_mg),
        .o_smoothed    (smoothed),
        .o_display     (display)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_display  <= display;
            r_smoothed <= smoothed;
            r_delta    <= scale_res.delta;
            r_in_band  <= scale_res.in_band;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DELTA_W-2*WEIGHT_W){1'b0}},
                            r_delta, r_smoothed, r_display};
    assign m_axis_tuser  = r_in_band;

endmodule

// ----- rtl/core/lcwc_scale.sv -----
// Tare subtraction, Q12.20 gain multiply with rounding and saturation, zero band.
// Combinational; depends on lcwc_pkg.
module lcwc_scale (
    input  logic signed [lcwc_pkg::RAW_W-1:0] i_raw,
    input  lcwc_pkg::t_cfg                    i_cfg,
    output lcwc_pkg::t_scale_res              o_res
);
    import lcwc_pkg::*;

    logic signed [DELTA_W-1:0] delta;
    logic                      neg;
    logic [DELTA_W-1:0]        mag_full;
    logic [RAW_W-1:0]          mag;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W:0]           prod_rnd;
    logic [QUOT_W-1:0]         quot;
    logic                      sat_pos;
    logic                      sat_neg;
    logic [WEIGHT_W-1:0]       scaled;
    logic                      in_band;

    always_comb begin
        delta    = DELTA_W'(i_raw) - DELTA_W'(i_cfg.tare_offset);
        neg      = delta[DELTA_W-1];
        mag_full = neg ? DELTA_W'(-delta) : DELTA_W'(delta);
        mag      = mag_full[RAW_W-1:0];   // |delta| < 2^24
        prod     = PROD_W'(mag) * PROD_W'(i_cfg.gain_q20);
        prod_rnd = {1'b0, prod} + ((PROD_W+1)'(1) << (FRAC_W-1));
        quot     = prod_rnd[PROD_W:FRAC_W];

        // positive limit 2^31-1, negative limit -2^31
        sat_pos = |quot[QUOT_W-1:WEIGHT_W-1];
        sat_neg = (|quot[QUOT_W-1:WEIGHT_W])
                  || (quot[WEIGHT_W-1] && (|quot[WEIGHT_W-2:0]));

        if (neg) begin
            scaled = sat_neg ? {1'b1, {(WEIGHT_W-1){1'b0}}} : -quot[WEIGHT_W-1:0];
        end else begin
            scaled = sat_pos ? {1'b0, {(WEIGHT_W-1){1'b1}}} : quot[WEIGHT_W-1:0];
        end

        in_band = i_cfg.zb_enable && (i_raw >= i_cfg.zb_low) && (i_raw <= i_cfg.zb_high);

        o_res.weight  = in_band ? '0 : $signed(scaled);
        o_res.delta   = delta;
        o_res.in_band = in_band;
    end

endmodule

// ----- rtl/core/lcwc_smooth.sv -----
// EMA smoother state (alpha 1/4) and display deadband.
// Depends on lcwc_pkg.
module lcwc_smooth (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic signed [lcwc_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic [lcwc_pkg::DBAND_W-1:0]          i_deadband_mg,
    output logic signed [lcwc_pkg::WEIGHT_W-1:0]  o_smoothed,
    output logic signed [lcwc_pkg::WEIGHT_W-1:0]  o_display
);
    import lcwc_pkg::*;

    logic signed [WEIGHT_W-1:0] r_smooth;
    logic                       r_have;
    logic signed [WEIGHT_W-1:0] n_smooth;
    logic signed [WEIGHT_W:0]   diff;
    logic signed [WEIGHT_W:0]   sum;
    logic [WEIGHT_W:0]          mag;

    always_comb begin
        diff = (WEIGHT_W+1)'(i_weight) - (WEIGHT_W+1)'(r_smooth);
        // arithmetic shift gives floor division by 4; result lies between
        // old state and new weight so it fits 32 bits
        sum  = (WEIGHT_W+1)'(r_smooth) + (diff >>> 2);
        n_smooth = r_have ? sum[WEIGHT_W-1:0] : i_weight;
        mag = n_smooth[WEIGHT_W-1] ? (WEIGHT_W+1)'(-(WEIGHT_W+1)'(n_smooth))
                                   : (WEIGHT_W+1)'(n_smooth);
        o_smoothed = n_smooth;
        o_display  = (mag < (WEIGHT_W+1)'(i_deadband_mg)) ? '0 : n_smooth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_have   <= 1'b0;
        end else if (i_advance) begin
            r_smooth <= n_smooth;
            r_have   <= 1'b1;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for load_cell_weight_conditioner_unit: directed and random
// sample streams checked word by word against a behavioural predictor.
// Depends on lcwc_pkg and the conditioner RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcwc_pkg::*;

    // spare register indexes, writes to these must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int     RANDOM_ITEMS = 1000;
    localparam int     PHASES       = 10;
    localparam int     DRAIN_SLACK  = 4;      // pipeline is two words deep
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     REPORT_MAX   = 10;
    localparam longint WEIGHT_MAX   = 64'sd2147483647;
    localparam longint WEIGHT_MIN   = -64'sd2147483648;

    // one conditioned result as the block should present it
    typedef struct {
        logic [RAW_W-1:0]    raw;
        logic [WEIGHT_W-1:0] display_mg;
        logic [WEIGHT_W-1:0] smoothed_mg;
        logic [DELTA_W-1:0]  delta;
        logic                in_band;
    } t_weight_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // register mirror, reset values
    logic signed [RAW_W-1:0] tare_mirror     = '0;
    logic [GAIN_W-1:0]       gain_mirror     = GAIN_RESET;
    logic signed [RAW_W-1:0] band_lo_mirror  = '0;
    logic signed [RAW_W-1:0] band_hi_mirror  = '0;
    logic                    band_en_mirror  = 1'b0;
    logic [DBAND_W-1:0]      deadband_mirror = DEADBAND_RESET;

    // smoother state mirror
    longint ema_mg      = 0;
    bit     ema_loaded  = 1'b0;

    t_weight_result pending_results[$];

    bit burst_mode = 1'b0;     // no idling on either side
    int stall_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int settings_count = 0;

    load_cell_weight_conditioner_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[load_cell_weight_conditioner_unit] ERROR");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (burst_mode) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_length() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Predict one result and advance the smoother mirror.
    // Scale: |delta| * gain, round half away from zero, drop 20 fraction bits,
    // saturate to 32 bits. EMA step is s + floor((w - s) / 4).
    function automatic t_weight_result condition_sample(logic signed [RAW_W-1:0] raw);
        t_weight_result     res;
        longint             raw_l;
        longint             delta;
        longint             weight;
        longint             step;
        longint             mag;
        longint             display;
        longint unsigned    delta_mag;
        longint unsigned    product;
        longint unsigned    quotient;
        logic               in_band;

        raw_l     = longint'(raw);
        delta     = raw_l - longint'(tare_mirror);
        delta_mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        product   = delta_mag * {32'd0, gain_mirror};
        quotient  = (product + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        weight    = (delta < 0) ? -longint'(quotient) : longint'(quotient);
        if (weight > WEIGHT_MAX)
            weight = WEIGHT_MAX;
        if (weight < WEIGHT_MIN)
            weight = WEIGHT_MIN;

        // inverted band holds nothing, falls out of the compare
        in_band = band_en_mirror && (raw_l >= longint'(band_lo_mirror))
                  && (raw_l <= longint'(band_hi_mirror));
        if (in_band)
            weight = 0;

        if (!ema_loaded) begin
            ema_mg     = weight;
            ema_loaded = 1'b1;
        end else begin
            step   = weight - ema_mg;
            ema_mg = ema_mg + (step >>> 2);
        end

        mag     = (ema_mg < 0) ? -ema_mg : ema_mg;
        display = (mag < longint'(deadband_mirror)) ? 0 : ema_mg;

        res.raw         = raw;
        res.display_mg  = display[WEIGHT_W-1:0];
        res.smoothed_mg = ema_mg[WEIGHT_W-1:0];
        res.delta       = delta[DELTA_W-1:0];
        res.in_band     = in_band;
        return res;
    endfunction

    function automatic void check_field(string field, logic [RAW_W-1:0] raw,
                                        logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch on %s for sample %h: expected %h, got %h",
                         field, raw, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_weight_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result word %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("display_weight_mg", want.raw, want.display_mg,
                            m_axis_tdata[31:0]);
                check_field("smoothed_weight_mg", want.raw, want.smoothed_mg,
                            m_axis_tdata[63:32]);
                check_field("delta_counts", want.raw, 32'(want.delta),
                            32'(m_axis_tdata[88:64]));
                check_field("in_zero_band", want.raw, 32'(want.in_band),
                            32'(m_axis_tuser));
            end
        end
    end

    // Send one sample word; tvalid stays up when the next word follows at once.
    task automatic send_sample(logic [RAW_W-1:0] raw);
        int gap;
        gap = 0;
        if (!burst_mode && $urandom_range(0, 99) >= 60)
            gap = idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_results.push_back(condition_sample(raw));
        samples_sent++;
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Register write, only while idle. Upper data bits are ignored by the block.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_TARE_OFFSET: tare_mirror     = value[RAW_W-1:0];
            CFG_GAIN_Q20:    gain_mirror     = value;
            CFG_ZB_LOW:      band_lo_mirror  = value[RAW_W-1:0];
            CFG_ZB_HIGH:     band_hi_mirror  = value[RAW_W-1:0];
            CFG_ZB_ENABLE:   band_en_mirror  = value[0];
            CFG_DEADBAND_MG: deadband_mirror = value[DBAND_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Default registers: first word loads the smoother, then the raw extremes.
    task automatic test_defaults();
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        wait_results_drained();
        settings_count++;
    endtask

    // Delta extremes with full-scale gain saturate both ways, zero gain,
    // and half-milligram rounding away from zero.
    task automatic test_tare_and_gain();
        write_reg(CFG_TARE_OFFSET, 32'hAB800000);
        write_reg(CFG_GAIN_Q20, 32'hFFFFFFFF);
        send_sample(24'h7FFFFF);
        wait_results_drained();
        write_reg(CFG_TARE_OFFSET, 32'h007FFFFF);
        send_sample(24'h800000);
        wait_results_drained();
        write_reg(CFG_GAIN_Q20, 32'd0);
        send_sample(24'h123456);
        wait_results_drained();
        write_reg(CFG_TARE_OFFSET, 32'd0);
        write_reg(CFG_GAIN_Q20, 32'h00080000);    // 0.5 mg per count
        send_sample(24'h000003);
        send_sample(24'hFFFFFD);
        wait_results_drained();
        settings_count += 4;
    endtask

    // Band edges inside and outside, then an inverted band that holds nothing.
    task automatic test_zero_band();
        write_reg(CFG_GAIN_Q20, 32'h00100000);
        write_reg(CFG_ZB_LOW, -32'sd100);
        write_reg(CFG_ZB_HIGH, 32'd100);
        write_reg(CFG_ZB_ENABLE, 32'hFFFFFFF1);
        send_sample(-24'sd100);
        send_sample(24'd100);
        send_sample(24'd101);
        send_sample(-24'sd101);
        wait_results_drained();
        write_reg(CFG_ZB_LOW, 32'd50);
        write_reg(CFG_ZB_HIGH, -32'sd50);
        send_sample(24'd0);
        wait_results_drained();
        write_reg(CFG_ZB_ENABLE, 32'd0);
        settings_count += 2;
    endtask

    // Smoother settles from above onto the deadband value: the compare is strict.
    // Then a deadband written beyond 20 bits and spare register indexes.
    task automatic test_deadband();
        write_reg(CFG_DEADBAND_MG, 32'd100);
        send_sample(24'd10000);
        repeat (40) send_sample(24'd100);
        wait_results_drained();
        write_reg(CFG_DEADBAND_MG, 32'hFFFFFFFF);
        write_reg(CFG_SPARE_6, 32'hFFFFFFFF);
        write_reg(CFG_SPARE_7, 32'h00000000);
        send_sample(24'h0F0000);
        wait_results_drained();
        settings_count += 2;
    endtask

    // Random register set, every register written, extremes now and then.
    task automatic randomise_settings();
        logic [RAW_W-1:0]   tare;
        logic [RAW_W-1:0]   band_lo;
        logic [RAW_W-1:0]   band_hi;
        logic [GAIN_W-1:0]  gain;
        logic [DBAND_W-1:0] dband;
        case ($urandom_range(0, 9))
            0:       tare = '0;
            1:       tare = 24'h7FFFFF;
            2:       tare = 24'h800000;
            default: tare = 24'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       gain = '0;
            1:       gain = '1;
            2:       gain = 32'h00100000;
            3:       gain = GAIN_RESET;
            4, 5:    gain = $urandom;
            default: gain = $urandom_range(0, 1 << 23);
        endcase
        band_lo = 24'($urandom);
        if ($urandom_range(0, 99) < 15)
            band_hi = band_lo - 24'($urandom_range(1, 5000));
        else
            band_hi = band_lo + 24'($urandom_range(0, 80000));
        case ($urandom_range(0, 9))
            0:       dband = '0;
            1:       dband = 20'd1000000;
            2:       dband = '1;
            default: dband = 20'($urandom_range(0, 200000));
        endcase
        write_reg(CFG_TARE_OFFSET, {8'($urandom), tare});
        write_reg(CFG_GAIN_Q20, gain);
        write_reg(CFG_ZB_LOW, {8'($urandom), band_lo});
        write_reg(CFG_ZB_HIGH, {8'($urandom), band_hi});
        write_reg(CFG_ZB_ENABLE, {31'($urandom), 1'($urandom_range(0, 99) < 65)});
        write_reg(CFG_DEADBAND_MG, {12'($urandom), dband});
        settings_count++;
    endtask

    // Mix of full-range noise, readings near the tare point, readings on and
    // around the band edges, and the raw extremes.
    function automatic logic [RAW_W-1:0] random_sample();
        int               pick;
        int               offset;
        logic [RAW_W-1:0] raw;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            raw = 24'($urandom);
        end else if (pick < 70) begin
            offset = int'($urandom_range(0, 400000)) - 200000;
            raw    = tare_mirror + offset[RAW_W-1:0];
        end else if (pick < 90) begin
            case ($urandom_range(0, 4))
                0:       raw = band_lo_mirror - 24'd1;
                1:       raw = band_lo_mirror;
                2:       raw = band_hi_mirror;
                3:       raw = band_hi_mirror + 24'd1;
                default: raw = band_lo_mirror + 24'($urandom_range(0, 60000));
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0:       raw = 24'h7FFFFF;
                1:       raw = 24'h800000;
                2:       raw = 24'h000000;
                default: raw = 24'hFFFFFF;
            endcase
        end
        return raw;
    endfunction

    // Random phases, one with no idling at all, one with a mid-phase pause
    // until every result has come back.
    task automatic test_random_stream();
        int per_phase;
        per_phase = RANDOM_ITEMS / PHASES;
        for (int phase = 0; phase < PHASES; phase++) begin
            randomise_settings();
            if (phase == 0)
                write_reg(CFG_DEADBAND_MG, 32'd1000000);
            if (phase == 1)
                write_reg(CFG_GAIN_Q20, 32'hFFFFFFFF);
            burst_mode = (phase == 3);
            for (int n = 0; n < per_phase; n++) begin
                if (phase == 5 && n == per_phase / 2)
                    wait_results_drained();
                send_sample(random_sample());
            end
            wait_results_drained();
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_tare_and_gain();
        test_zero_band();
        test_deadband();
        test_random_stream();

        wait_results_drained();
        $display("Ran %0d samples through %0d register settings; %0d results checked.",
                 samples_sent, settings_count, results_checked);
        $display("Covered saturation, rounding, zero band edges, strict deadband, idling.");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[load_cell_weight_conditioner_unit] OK");
        end else begin
            $display("%0d failures", mismatch_count);
            $display("[load_cell_weight_conditioner_unit] ERROR");
        end
        $finish;
    end

endmodule
